>>> rtl/core/mpis_pkg.sv
// ----------------------------------------------------------------------------
// mpis_pkg
// Shared types and constants for the port initialization sequencer.
// ----------------------------------------------------------------------------
package mpis_pkg;

	// tuning
	localparam int MAX_ATTEMPTS      = 3;
	localparam int RESET_WAIT_POLLS  = 1000;
	localparam int STEP1_DELAY_POLLS = 1;

	// item commands
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_POLL  = 1'b1;

	// config register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_HIGH = 2'd1;

	// SA register bits
	localparam logic [15:0] SA_ERR   = 16'o100000;
	localparam logic [15:0] SA_S4    = 16'o040000;
	localparam logic [15:0] SA_S3    = 16'o020000;
	localparam logic [15:0] SA_S2    = 16'o010000;
	localparam logic [15:0] SA_S1    = 16'o004000;
	localparam logic [15:0] SA_SMASK = 16'o074000;
	localparam logic [15:0] SA_CHECK = SA_ERR | SA_SMASK;
	localparam logic [15:0] VEC_WORD = SA_ERR | (16'o154 / 16'd4);
	localparam logic [15:0] SA_GO    = 16'd1;
	localparam logic [10:0] ID_MASK  = 11'o3777;
	localparam logic [7:0]  STCON_END = 8'o204;

	// phase codes
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_RESET = 4'd1;
	localparam logic [3:0] PH_S1    = 4'd2;
	localparam logic [3:0] PH_S2    = 4'd3;
	localparam logic [3:0] PH_S3    = 4'd4;
	localparam logic [3:0] PH_S4    = 4'd5;
	localparam logic [3:0] PH_CMD   = 4'd6;
	localparam logic [3:0] PH_RUN   = 4'd7;
	localparam logic [3:0] PH_FAIL  = 4'd8;

	typedef struct packed {
		logic        cmd;
		logic [15:0] sa_value;
		logic        cmd_owned;
		logic        rsp_owned;
		logic [7:0]  rsp_endcode;
		logic [15:0] rsp_status;
	} mpis_item_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [1:0]  attempt;
		logic        ip_write;
		logic        sa_write;
		logic [15:0] sa_write_value;
		logic        cmd_post;
		logic        init_done;
		logic        init_failed;
		logic [10:0] controller_id;
	} mpis_result_t;

endpackage

>>> rtl/core/mpis_in_stage.sv
// ----------------------------------------------------------------------------
// mpis_in_stage
// Input register: captures one word per cycle while not stalled, holds it until
// the core consumes it into the result register.
// ----------------------------------------------------------------------------
module mpis_in_stage import mpis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  mpis_item_t item_in,
	input  logic       out_free,
	output logic       valid_s1,
	output mpis_item_t item_s1
);

	logic take;

	assign in_stall = valid_s1 && !out_free;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

>>> rtl/core/mpis_core.sv
// ----------------------------------------------------------------------------
// mpis_core
// Sequencer state, config registers and the per-word next-state logic.
// ----------------------------------------------------------------------------
module mpis_core import mpis_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 fire,
	input  mpis_item_t           item,
	output mpis_result_t         res
);

	logic [3:0]  phase_q, phase_d;
	logic [1:0]  attempt_q, attempt_d;
	logic [15:0] poll_q, poll_d;
	logic [10:0] id_q, id_d;
	logic [15:0] ring_low_q;
	logic [5:0]  ring_high_q;

	logic        ip, saw, post, fail;
	logic [15:0] sav;
	logic [15:0] sa_chk;
	logic [16:0] poll_inc;

	assign sa_chk   = item.sa_value & SA_CHECK;
	assign poll_inc = {1'b0, poll_q} + 17'd1;

	always_comb begin
		phase_d   = phase_q;
		attempt_d = attempt_q;
		poll_d    = poll_q;
		id_d      = id_q;
		ip        = 1'b0;
		saw       = 1'b0;
		sav       = '0;
		post      = 1'b0;
		fail      = 1'b0;
		if (item.cmd == CMD_START) begin
			attempt_d = 2'd1;
			phase_d   = PH_RESET;
			poll_d    = '0;
			ip        = 1'b1;
		end else begin
			unique case (phase_q)
				PH_RESET: begin
					if (item.sa_value == '0 || poll_q >= 16'(RESET_WAIT_POLLS)) begin
						phase_d = PH_S1;
						poll_d  = '0;
					end else if (poll_q != 16'hFFFF) begin
						poll_d = poll_inc[15:0];
					end
				end
				PH_S1: begin
					if (poll_inc >= 17'(STEP1_DELAY_POLLS)) begin
						if (sa_chk == SA_S1) begin
							saw     = 1'b1;
							sav     = VEC_WORD;
							phase_d = PH_S2;
						end else begin
							fail = 1'b1;
						end
					end else begin
						poll_d = poll_inc[15:0];
					end
				end
				PH_S2: begin
					if ((item.sa_value & SA_S2) != '0) begin
						if (sa_chk == SA_S2) begin
							saw     = 1'b1;
							sav     = ring_low_q;
							phase_d = PH_S3;
						end else begin
							fail = 1'b1;
						end
					end
				end
				PH_S3: begin
					if ((item.sa_value & SA_S3) != '0) begin
						if (sa_chk == SA_S3) begin
							saw     = 1'b1;
							sav     = {10'd0, ring_high_q};
							phase_d = PH_S4;
						end else begin
							fail = 1'b1;
						end
					end
				end
				PH_S4: begin
					if ((item.sa_value & SA_S4) != '0) begin
						if (sa_chk == SA_S4) begin
							id_d    = item.sa_value[10:0] & ID_MASK;
							saw     = 1'b1;
							sav     = SA_GO;
							post    = 1'b1;
							phase_d = PH_CMD;
						end else begin
							fail = 1'b1;
						end
					end
				end
				PH_CMD: begin
					if (item.cmd_owned || item.rsp_owned) begin
						fail = (sa_chk != '0);
					end else if (item.rsp_endcode == STCON_END &&
						item.rsp_status[4:0] == 5'd0) begin
						phase_d = PH_RUN;
					end else begin
						fail = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (fail) begin
				if (attempt_q < 2'(MAX_ATTEMPTS)) begin
					attempt_d = attempt_q + 2'd1;
					phase_d   = PH_RESET;
					poll_d    = '0;
					ip        = 1'b1;
				end else begin
					phase_d = PH_FAIL;
				end
			end
		end
	end

	always_comb begin
		res.phase          = phase_d;
		res.attempt        = attempt_d;
		res.ip_write       = ip;
		res.sa_write       = saw;
		res.sa_write_value = sav;
		res.cmd_post       = post;
		res.init_done      = (phase_d == PH_RUN);
		res.init_failed    = (phase_d == PH_FAIL);
		res.controller_id  = id_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			attempt_q <= '0;
			poll_q    <= '0;
			id_q      <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			attempt_q <= attempt_d;
			poll_q    <= poll_d;
			id_q      <= id_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_low_q  <= '0;
			ring_high_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_RING_LOW) begin
				ring_low_q <= cfg_data;
			end
			if (cfg_index == CFG_RING_HIGH) begin
				ring_high_q <= cfg_data[5:0];
			end
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_FAIL)
		else $error("phase register out of range");

	a_post_go: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.cmd_post |-> res.sa_write && res.sa_write_value == SA_GO &&
		phase_q == PH_S4)
		else $error("command post without GO write");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.ip_write |=> phase_q == PH_RESET && poll_q == '0 &&
		attempt_q != '0)
		else $error("attempt start did not enter reset wait");

	a_fail_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAIL |-> attempt_q == 2'(MAX_ATTEMPTS))
		else $error("failed with attempts remaining");

endmodule

>>> rtl/core/mpis_out_stage.sv
// ----------------------------------------------------------------------------
// mpis_out_stage
// Result register: holds a finished word until the consumer takes it.
// ----------------------------------------------------------------------------
module mpis_out_stage import mpis_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  mpis_result_t res_in,
	input  logic         out_stall,
	output logic         out_free,
	output logic         out_valid,
	output mpis_result_t res_s2
);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_s2 <= res_in;
		end
	end

endmodule

>>> rtl/core/mscp_port_init_sequencer_unit.sv
// ----------------------------------------------------------------------------
// mscp_port_init_sequencer_unit
// Host side of the four-step port initialization handshake with retries.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------
//  in      | in  | in_valid / in_stall      | cmd, sa_value, cmd_owned,
//          |     |                          | rsp_owned, rsp_endcode, rsp_status
//  out     | out | out_valid / out_stall    | phase, attempt, ip_write, sa_write,
//          |     |                          | sa_write_value, cmd_post, init_done,
//          |     |                          | init_failed, controller_id
//  cfg     | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  One word accepted per cycle while in_stall is low; its result passes through
//  the input register, then the result register, to the output ports.
//  The sequencer state updates as the word moves from the input register
//  into the result register, so the next word already sees it.
//  An output stall holds the result register; in_stall is high whenever the
//  input register holds a word and the result register cannot take it.
//  cfg_ready is always high; writes are expected while the unit is idle.
//  arst_n clears the phase, attempt and poll counters, saved ID and config.
//
module mscp_port_init_sequencer_unit import mpis_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// config write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [15:0]          sa_value,
	input  logic                 cmd_owned,
	input  logic                 rsp_owned,
	input  logic [7:0]           rsp_endcode,
	input  logic [15:0]          rsp_status,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           phase,
	output logic [1:0]           attempt,
	output logic                 ip_write,
	output logic                 sa_write,
	output logic [15:0]          sa_write_value,
	output logic                 cmd_post,
	output logic                 init_done,
	output logic                 init_failed,
	output logic [10:0]          controller_id
);

	mpis_item_t   item_in;
	mpis_item_t   item_s1;
	mpis_result_t res_next;
	mpis_result_t res_s2;
	logic         valid_s1;
	logic         out_free;
	logic         fire;

	assign cfg_ready = 1'b1;

	assign item_in.cmd         = cmd;
	assign item_in.sa_value    = sa_value;
	assign item_in.cmd_owned   = cmd_owned;
	assign item_in.rsp_owned   = rsp_owned;
	assign item_in.rsp_endcode = rsp_endcode;
	assign item_in.rsp_status  = rsp_status;

	// word leaves the input register into the result register
	assign fire = valid_s1 && out_free;

	mpis_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mpis_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.res       (res_next)
	);

	mpis_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res_in    (res_next),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_s2    (res_s2)
	);

	assign phase          = res_s2.phase;
	assign attempt        = res_s2.attempt;
	assign ip_write       = res_s2.ip_write;
	assign sa_write       = res_s2.sa_write;
	assign sa_write_value = res_s2.sa_write_value;
	assign cmd_post       = res_s2.cmd_post;
	assign init_done      = res_s2.init_done;
	assign init_failed    = res_s2.init_failed;
	assign controller_id  = res_s2.controller_id;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the port initialization sequencer: a short table of
// directed words, then random words shaped into mostly well-formed step
// sequences, scored against an in-bench model of the handshake (typed rows: fixed results).
// ----------------------------------------------------------------------------
module tb;
	import mpis_pkg::*;

	// bench tuning
	localparam int RANDOM_PHASES   = 5;
	localparam int WORDS_PER_PHASE = 130;   // phase two also carries the long reset wait
	localparam int HOLD_CYCLES     = 300;   // long output hold-off
	localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake at all
	localparam int SETTLE_CYCLES   = 4;     // pipeline is two deep
	localparam logic [15:0] STATUS_MASK = 16'o37;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index

	typedef enum logic [1:0] {STEP_WAIT, STEP_PASS, STEP_FAIL} step_verdict_t;

	// one directed word; want is only used when typed is set
	typedef struct packed {
		mpis_item_t   w;
		logic         typed;
		mpis_result_t want;
	} seq_row_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [15:0]          cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 cmd         = CMD_START;
	logic [15:0]          sa_value    = '0;
	logic                 cmd_owned   = 1'b0;
	logic                 rsp_owned   = 1'b0;
	logic [7:0]           rsp_endcode = '0;
	logic [15:0]          rsp_status  = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [3:0]           phase;
	logic [1:0]           attempt;
	logic                 ip_write;
	logic                 sa_write;
	logic [15:0]          sa_write_value;
	logic                 cmd_post;
	logic                 init_done;
	logic                 init_failed;
	logic [10:0]          controller_id;

	mscp_port_init_sequencer_unit dut (.*);

	// sequencer model state, tracks the DUT word by word
	logic [3:0]  ph_q       = PH_IDLE;
	logic [1:0]  att_q      = '0;
	int unsigned polls_q    = 0;
	logic [10:0] id_q       = '0;
	logic [15:0] ring_low_q = '0;
	logic [5:0]  ring_high_q = '0;

	mpis_result_t status_due[$];      // predicted result words, oldest first
	seq_row_t     directed_rows[$];
	int unsigned  mismatches   = 0;
	int           burst_left   = 0;   // sender words left with no gap
	bit           hold_req     = 1'b0;
	bit           long_pending = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// model of the handshake
	// ------------------------------------------------------------------

	// steps two..four: no awaited bit = keep waiting; awaited bit plus any
	// other step or error bit = failure
	function automatic step_verdict_t step_verdict(input logic [15:0] sa, input logic [15:0] step);
		if ((sa & step) == 16'd0)
			return STEP_WAIT;
		return ((sa & SA_CHECK) == step) ? STEP_PASS : STEP_FAIL;
	endfunction

	function automatic mpis_result_t predict_status(input mpis_item_t w);
		mpis_result_t  r;
		step_verdict_t v;
		logic          restart;
		logic          fault;
		r = '0;
		restart = 1'b0;
		fault = 1'b0;
		if (w.cmd == CMD_START) begin
			// a start restarts from attempt one in any phase, ID is kept
			att_q = 2'd0;
			restart = 1'b1;
		end else begin
			case (ph_q)
				PH_RESET: begin
					// SA clear, or the poll that finds the count at the limit
					if (w.sa_value == 16'd0 || polls_q >= RESET_WAIT_POLLS) begin
						ph_q = PH_S1;
						polls_q = 0;
					end else if (polls_q < 32'hFFFF) begin
						polls_q++;
					end
				end
				PH_S1: begin
					if (polls_q + 1 >= STEP1_DELAY_POLLS) begin
						if ((w.sa_value & SA_CHECK) == SA_S1) begin
							r.sa_write = 1'b1;
							r.sa_write_value = VEC_WORD;
							ph_q = PH_S2;
						end else begin
							fault = 1'b1;
						end
					end else begin
						polls_q++;
					end
				end
				PH_S2: begin
					v = step_verdict(w.sa_value, SA_S2);
					if (v == STEP_PASS) begin
						r.sa_write = 1'b1;
						r.sa_write_value = ring_low_q;
						ph_q = PH_S3;
					end else if (v == STEP_FAIL) begin
						fault = 1'b1;
					end
				end
				PH_S3: begin
					v = step_verdict(w.sa_value, SA_S3);
					if (v == STEP_PASS) begin
						r.sa_write = 1'b1;
						r.sa_write_value = {10'd0, ring_high_q};
						ph_q = PH_S4;
					end else if (v == STEP_FAIL) begin
						fault = 1'b1;
					end
				end
				PH_S4: begin
					v = step_verdict(w.sa_value, SA_S4);
					if (v == STEP_PASS) begin
						id_q = w.sa_value[10:0] & ID_MASK;
						r.sa_write = 1'b1;
						r.sa_write_value = SA_GO;
						r.cmd_post = 1'b1;
						ph_q = PH_CMD;
					end else if (v == STEP_FAIL) begin
						fault = 1'b1;
					end
				end
				PH_CMD: begin
					if (w.cmd_owned || w.rsp_owned) begin
						if ((w.sa_value & SA_CHECK) != 16'd0)
							fault = 1'b1;
					end else if (w.rsp_endcode == STCON_END &&
							(w.rsp_status & STATUS_MASK) == 16'd0) begin
						ph_q = PH_RUN;
					end else begin
						fault = 1'b1;
					end
				end
				default: ;  // idle, run, failed: polls do nothing
			endcase
		end
		if (fault) begin
			if (att_q < MAX_ATTEMPTS)
				restart = 1'b1;
			else
				ph_q = PH_FAIL;
		end
		if (restart) begin
			att_q = att_q + 2'd1;
			ph_q = PH_RESET;
			polls_q = 0;
			r.ip_write = 1'b1;
		end
		r.phase = ph_q;
		r.attempt = att_q;
		r.init_done = (ph_q == PH_RUN);
		r.init_failed = (ph_q == PH_FAIL);
		r.controller_id = id_q;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// word builders
	// ------------------------------------------------------------------

	function automatic logic [15:0] rnd16();
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic mpis_item_t make_word(input logic c, input logic [15:0] sa,
			input logic cown, input logic rown, input logic [7:0] endc, input logic [15:0] stat);
		mpis_item_t w;
		w.cmd = c;
		w.sa_value = sa;
		w.cmd_owned = cown;
		w.rsp_owned = rown;
		w.rsp_endcode = endc;
		w.rsp_status = stat;
		return w;
	endfunction

	function automatic mpis_result_t want_status(input logic [3:0] ph, input logic [1:0] att,
			input logic ip, input logic saw, input logic [15:0] sav, input logic post,
			input logic done, input logic flt, input logic [10:0] id);
		mpis_result_t r;
		r.phase = ph;
		r.attempt = att;
		r.ip_write = ip;
		r.sa_write = saw;
		r.sa_write_value = sav;
		r.cmd_post = post;
		r.init_done = done;
		r.init_failed = flt;
		r.controller_id = id;
		return r;
	endfunction

	// SA sample for a step wait: mostly the clean step, some waits, some bad
	function automatic logic [15:0] step_sa(input logic [15:0] step);
		logic [15:0] lo;
		logic [15:0] extra;
		int          r;
		lo = rnd16() & ~SA_CHECK;
		r = $urandom_range(0, 99);
		if (r < 10)
			return rnd16() & ~step;
		if (r < 88)
			return step | lo;
		extra = rnd16() & SA_CHECK & ~step;
		if (extra == 16'd0)
			extra = SA_ERR;
		return step | lo | extra;
	endfunction

	// random word steered by the model's phase so most runs get deep
	function automatic mpis_item_t next_word();
		mpis_item_t w;
		int         r;
		w = make_word(CMD_POLL, rnd16(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)), rnd16());
		r = $urandom_range(0, 99);
		if (r < 3) begin
			w.cmd = CMD_START;
			return w;
		end
		if (r < 8)
			return w;  // pure noise
		case (ph_q)
			PH_RESET: if ($urandom_range(0, 3) != 0) w.sa_value = 16'd0;
			PH_S1:    w.sa_value = step_sa(SA_S1);
			PH_S2:    w.sa_value = step_sa(SA_S2);
			PH_S3:    w.sa_value = step_sa(SA_S3);
			PH_S4:    w.sa_value = step_sa(SA_S4);
			PH_CMD: begin
				if ($urandom_range(0, 3) == 0) begin
					// descriptors still out; mostly a quiet SA
					if (!w.cmd_owned && !w.rsp_owned)
						w.rsp_owned = 1'b1;
					if ($urandom_range(0, 3) != 0)
						w.sa_value = w.sa_value & ~SA_CHECK;
				end else begin
					w.cmd_owned = 1'b0;
					w.rsp_owned = 1'b0;
					r = $urandom_range(0, 9);
					if (r < 7) begin
						w.rsp_endcode = STCON_END;
						w.rsp_status = w.rsp_status & ~STATUS_MASK;
					end else if (r < 8) begin
						w.rsp_endcode = STCON_END;
					end
				end
			end
			default: if ($urandom_range(0, 1) != 0) w.cmd = CMD_START;
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------

	// sender gap: mostly none or short, now and then long, plus bursts
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// offer one word, hold it until taken, then log its predicted result;
	// valid is only dropped here when a gap is due
	task automatic send_word(input mpis_item_t w, input logic typed, input mpis_result_t want);
		mpis_result_t pred;
		int           gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{cmd, sa_value, cmd_owned, rsp_owned, rsp_endcode, rsp_status} <= w;
		do @(posedge clk); while (in_stall);
		pred = predict_status(w);
		status_due.push_back(typed ? want : pred);
	endtask

	// caller lowers cfg_valid once the batch is done
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RING_LOW:  ring_low_q = val;
			CFG_RING_HIGH: ring_high_q = val[5:0];
			default: ;
		endcase
	endtask

	task automatic set_ring_base(input logic [15:0] low, input logic [5:0] high, input bit spare);
		write_reg(CFG_RING_LOW, low);
		write_reg(CFG_RING_HIGH, {10'd0, high});
		if (spare)
			write_reg(CFG_SPARE, rnd16());
		cfg_valid <= 1'b0;
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n);
		int         counted;
		mpis_item_t w;
		counted = 0;
		while (counted < n) begin
			// one reset wait that runs all the way to the poll limit
			if (long_pending && ph_q == PH_RESET) begin
				long_pending = 1'b0;
				while (ph_q == PH_RESET) begin
					send_word(make_word(CMD_POLL, rnd16() | 16'd1, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rnd16()),
						1'b0, '0);
					counted++;
				end
			end
			w = next_word();
			send_word(w, 1'b0, '0);
			counted++;
		end
	endtask

	task automatic add_row(input mpis_item_t w, input logic typed, input mpis_result_t want);
		seq_row_t row;
		row.w = w;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// receiver stall: free runs, short stalls, rare long ones, and one
	// long hold-off on request so the input side backs up
	initial begin : result_sink
		int run_left;
		int r;
		run_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				run_left = HOLD_CYCLES;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					out_stall <= 1'b0;
					run_left = $urandom_range(0, 24);
				end else if (r < 88) begin
					out_stall <= 1'b1;
					run_left = $urandom_range(0, 2);
				end else if (r < 97) begin
					out_stall <= 1'b1;
					run_left = $urandom_range(3, 14);
				end else begin
					out_stall <= 1'b1;
					run_left = $urandom_range(20, 60);
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// score each accepted result word against the oldest prediction
	always @(posedge clk) begin : result_check
		mpis_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				$error("result word arrived with nothing outstanding");
				mismatches++;
			end else begin
				want = status_due.pop_front();
				check_field("phase", want.phase, phase);
				check_field("attempt", want.attempt, attempt);
				check_field("ip_write", want.ip_write, ip_write);
				check_field("sa_write", want.sa_write, sa_write);
				check_field("sa_write_value", want.sa_write_value, sa_write_value);
				check_field("cmd_post", want.cmd_post, cmd_post);
				check_field("init_done", want.init_done, init_done);
				check_field("init_failed", want.init_failed, init_failed);
				check_field("controller_id", want.controller_id, controller_id);
			end
		end
	end

	// no handshake on any channel for too long: hung
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int p;

		// Directed walk. Typed rows: state right after reset, the extreme
		// controller ID, three failure paths and the final pass. Others go
		// through the model.
		add_row(make_word(CMD_POLL, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF), 1'b1,
			want_status(PH_IDLE, 2'd0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 11'd0));
		add_row(make_word(CMD_START, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF), 1'b1,
			want_status(PH_RESET, 2'd1, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 11'd0));
		add_row(make_word(CMD_POLL, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S1, 1'b0, 1'b0, 8'd0, 16'd0), 1'b1,
			want_status(PH_S2, 2'd1, 1'b0, 1'b1, VEC_WORD, 1'b0, 1'b0, 1'b0, 11'd0));
		// step two bit not up yet: keeps waiting
		add_row(make_word(CMD_POLL, SA_S1 | 16'h07FF, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S2 | 16'h07FF, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S3, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S4 | 16'h07FF, 1'b0, 1'b0, 8'd0, 16'd0), 1'b1,
			want_status(PH_CMD, 2'd1, 1'b0, 1'b1, SA_GO, 1'b1, 1'b0, 1'b0, 11'h7FF));
		// command descriptor still out, SA quiet: wait
		add_row(make_word(CMD_POLL, 16'd0, 1'b1, 1'b0, 8'hFF, 16'hFFFF), 1'b0, '0);
		// step bit while response still owned: second attempt
		add_row(make_word(CMD_POLL, SA_S1, 1'b0, 1'b1, STCON_END, 16'd0), 1'b1,
			want_status(PH_RESET, 2'd2, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 11'h7FF));
		add_row(make_word(CMD_POLL, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		// error bit with step one: third attempt
		add_row(make_word(CMD_POLL, SA_S1 | SA_ERR, 1'b0, 1'b0, 8'd0, 16'd0), 1'b1,
			want_status(PH_RESET, 2'd3, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 11'h7FF));
		add_row(make_word(CMD_POLL, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		// wrong step at step one, attempts used up
		add_row(make_word(CMD_POLL, SA_S2, 1'b0, 1'b0, 8'd0, 16'd0), 1'b1,
			want_status(PH_FAIL, 2'd3, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b1, 11'h7FF));
		// restart out of failed
		add_row(make_word(CMD_START, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S1, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		// two step bits at once
		add_row(make_word(CMD_POLL, SA_S2 | SA_S3, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S1, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S2, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S3 | 16'h0555, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		add_row(make_word(CMD_POLL, SA_S4, 1'b0, 1'b0, 8'd0, 16'd0), 1'b0, '0);
		// both released, good end code, status code clear: run
		add_row(make_word(CMD_POLL, 16'hFFFF, 1'b0, 1'b0, STCON_END, 16'hFFE0), 1'b1,
			want_status(PH_RUN, 2'd2, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0, 11'd0));
		add_row(make_word(CMD_POLL, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF), 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_ring_base(16'hFFFF, 6'd63, 1'b0);
		foreach (directed_rows[i])
			send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

		// random phases, ring base rewritten while nothing is in flight
		for (p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
				0:       set_ring_base(16'd0, 6'd0, 1'b0);
				1:       set_ring_base(16'hFFFF, 6'd63, 1'b1);
				default: set_ring_base(rnd16(), 6'($urandom_range(0, 63)), 1'b0);
			endcase
			if (p == 1) begin
				// sender keeps offering through the long hold-off
				hold_req = 1'b1;
				burst_left = HOLD_CYCLES + 100;
			end
			if (p == 2)
				long_pending = 1'b1;
			run_random(WORDS_PER_PHASE);
		end
		drain();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
